// ===== rtl/core/cts_pkg.sv =====
`timescale 1ns / 1ps
// cts_pkg: shared types, codes and sizes for the CAN periodic transmit scheduler
// no dependencies

package cts_pkg;

  localparam int SINGLE_DEPTH = 16;
  localparam int CYCLIC_DEPTH = 16;
  localparam int LIST_DEPTH   = (SINGLE_DEPTH > CYCLIC_DEPTH) ? SINGLE_DEPTH : CYCLIC_DEPTH;
  localparam int LIST_IW      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int LIST_CW      = $clog2(LIST_DEPTH + 1);

  localparam int ID_W   = 29;
  localparam int LEN_W  = 4;
  localparam int DATA_W = 64;
  localparam int TIME_W = 32;
  localparam int ACT_W  = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD_SINGLE = 3'd0,
    ACT_ADD_CYCLIC = 3'd1,
    ACT_DEL_CYCLIC = 3'd2,
    ACT_CLR_CYCLIC = 3'd3,
    ACT_TICK       = 3'd4
  } act_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_FIND,
    ST_SCAN_S,
    ST_SCAN_C,
    ST_DIV,
    ST_UPD,
    ST_RESP
  } state_e;

  // one stored frame; period unused in the one-shot list
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
    logic [TIME_W-1:0] tm;
    logic [TIME_W-1:0] per;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic               shift_en;
    logic [LIST_IW-1:0] k;
    logic               load_en;
    logic [LIST_IW-1:0] tail;
  } list_ctrl_t;

endpackage

// ===== rtl/core/cts_cell.sv =====
`timescale 1ns / 1ps
// cts_cell: one entry of a frame list, takes its neighbour or a new frame
// depends on cts_pkg

module cts_cell import cts_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     nbr_i,
  input  entry_t     new_i,
  output entry_t     q_o
);

  entry_t ent_q, ent_d;

  // load wins over shift
  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.load) begin
      ent_d = new_i;
    end else if (ctrl_i.shift) begin
      ent_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign q_o = ent_q;

endmodule

// ===== rtl/core/cts_list.sv =====
`timescale 1ns / 1ps
// cts_list: row of cells forming a compacting frame list with one read port
// depends on cts_pkg, cts_cell

module cts_list import cts_pkg::*; (
  input  logic               clk_i,
  input  list_ctrl_t         ctrl_i,
  input  entry_t             new_i,
  input  logic [LIST_IW-1:0] rd_idx_i,
  output entry_t             rd_o
);

  entry_t ent [LIST_DEPTH];

  // each cell shifts from its upper neighbour at or above the removed slot
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    cell_ctrl_t cc;
    entry_t     nbr;
    assign cc.load  = ctrl_i.load_en && (ctrl_i.tail == LIST_IW'(g));
    assign cc.shift = ctrl_i.shift_en && (LIST_IW'(g) >= ctrl_i.k);
    if (g == LIST_DEPTH - 1) begin : g_last
      assign nbr = ent[g];
    end else begin : g_mid
      assign nbr = ent[g+1];
    end
    cts_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cc),
      .nbr_i  (nbr),
      .new_i  (new_i),
      .q_o    (ent[g])
    );
  end

  assign rd_o = ent[rd_idx_i];

endmodule

// ===== rtl/core/cts_div.sv =====
`timescale 1ns / 1ps
// cts_div: restoring divider giving the remainder, one bit per cycle
// depends on cts_pkg

module cts_div import cts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TIME_W-1:0] num_i,
  input  logic [TIME_W-1:0] den_i,
  output logic              done_o,
  output logic [TIME_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(TIME_W);

  logic              run_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [TIME_W-1:0] num_q, den_q, rem_q;
  logic [TIME_W:0]   trial;
  logic [TIME_W-1:0] rem_d;

  // one trial subtraction
  always_comb begin
    trial = {rem_q, num_q[TIME_W-1]};
    if (trial >= {1'b0, den_q}) begin
      rem_d = TIME_W'(trial - {1'b0, den_q});
    end else begin
      rem_d = trial[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(TIME_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      num_q <= num_q << 1;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/can_tx_periodic_scheduler_unit.sv =====
`timescale 1ns / 1ps
// can_tx_periodic_scheduler_unit: one request at a time, result strobed on done_o
// one-shot adds store then respond; periodic add/delete search, update, respond
// a clear responds at once; a tick: scan one-shot, scan periodic, divide, update, respond
// next request taken the cycle after done_o; the receiver cannot stall
// reset clears both list counts; list cells themselves are not cleared
// depends on cts_pkg, cts_list, cts_div

module can_tx_periodic_scheduler_unit import cts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [ID_W-1:0]   frame_id_i,
  input  logic [LEN_W-1:0]  frame_len_i,
  input  logic [DATA_W-1:0] frame_data_i,
  input  logic [TIME_W-1:0] time_ms_i,
  input  logic [TIME_W-1:0] interval_ms_i,
  input  logic              tx_ready_i,
  output logic              done_o,
  output logic              sent_o,
  output logic              sent_kind_o,
  output logic [ID_W-1:0]   tx_id_o,
  output logic [LEN_W-1:0]  tx_len_o,
  output logic [DATA_W-1:0] tx_data_o,
  output logic              any_due_o,
  output logic              list_full_o
);

  state_e state_q, state_d;

  logic [ACT_W-1:0]   act_q;
  logic               ready_q;
  logic [TIME_W-1:0]  now_q;
  entry_t             new_s_q, new_c_q;
  logic [LIST_CW-1:0] scnt_q, ccnt_q, idx_q;
  logic               found_q;

  logic               sent_q, kind_q, due_q, full_q;
  logic [ID_W-1:0]    id_q;
  logic [LEN_W-1:0]   len_q;
  logic [DATA_W-1:0]  data_q;

  list_ctrl_t s_ctrl, c_ctrl;
  entry_t     s_rd, c_rd;
  logic       div_start, div_done;
  logic [TIME_W-1:0] div_rem;

  logic accept, s_end, c_end, s_hit, c_hit, id_hit, c_full;

  assign accept = start && !busy;
  assign s_end  = idx_q >= scnt_q;
  assign c_end  = idx_q >= ccnt_q;
  assign s_hit  = s_rd.tm < now_q;
  assign c_hit  = c_rd.tm < now_q;
  assign id_hit = c_rd.id == new_c_q.id;
  assign c_full = ccnt_q == LIST_CW'(CYCLIC_DEPTH);

  cts_list u_single (
    .clk_i    (clk_i),
    .ctrl_i   (s_ctrl),
    .new_i    (new_s_q),
    .rd_idx_i (idx_q[LIST_IW-1:0]),
    .rd_o     (s_rd)
  );

  cts_list u_cyclic (
    .clk_i    (clk_i),
    .ctrl_i   (c_ctrl),
    .new_i    (new_c_q),
    .rd_idx_i (idx_q[LIST_IW-1:0]),
    .rd_o     (c_rd)
  );

  cts_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (now_q - c_rd.tm),
    .den_i   (c_rd.per),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (act_e'(action_i))
            ACT_ADD_SINGLE: state_d = ST_ADD;
            ACT_ADD_CYCLIC: state_d = ST_FIND;
            ACT_DEL_CYCLIC: state_d = ST_FIND;
            ACT_TICK:       state_d = ST_SCAN_S;
            default:        state_d = ST_RESP;
          endcase
        end
      end
      ST_ADD:    state_d = ST_RESP;
      ST_FIND: begin
        if (c_end || id_hit) state_d = ST_UPD;
      end
      ST_SCAN_S: begin
        if (s_end) state_d = ST_SCAN_C;
        else if (s_hit) state_d = ready_q ? ST_RESP : ST_SCAN_C;
      end
      ST_SCAN_C: begin
        if (c_end) state_d = ST_RESP;
        else if (c_hit) state_d = ready_q ? ST_DIV : ST_RESP;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_UPD;
      end
      ST_UPD:    state_d = ST_RESP;
      ST_RESP:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // list controls and divider start
  always_comb begin
    s_ctrl    = '0;
    c_ctrl    = '0;
    div_start = 1'b0;
    case (state_q)
      ST_ADD: begin
        s_ctrl.load_en = scnt_q != LIST_CW'(SINGLE_DEPTH);
        s_ctrl.tail    = scnt_q[LIST_IW-1:0];
      end
      ST_SCAN_S: begin
        s_ctrl.shift_en = !s_end && s_hit && ready_q;
        s_ctrl.k        = idx_q[LIST_IW-1:0];
      end
      ST_SCAN_C: begin
        div_start = !c_end && c_hit && ready_q;
      end
      ST_UPD: begin
        c_ctrl.shift_en = found_q;
        c_ctrl.k        = idx_q[LIST_IW-1:0];
        if (act_e'(act_q) != ACT_DEL_CYCLIC) begin
          c_ctrl.load_en = found_q || !c_full;
          c_ctrl.tail    = found_q ? LIST_IW'(ccnt_q - 1'b1) : ccnt_q[LIST_IW-1:0];
        end
      end
      default: begin
        s_ctrl = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      scnt_q  <= '0;
      ccnt_q  <= '0;
      idx_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          idx_q   <= '0;
          found_q <= 1'b0;
          if (accept && act_e'(action_i) == ACT_CLR_CYCLIC) ccnt_q <= '0;
        end
        ST_ADD: begin
          if (s_ctrl.load_en) scnt_q <= scnt_q + 1'b1;
        end
        ST_FIND: begin
          if (!c_end && id_hit) found_q <= 1'b1;
          else if (!c_end) idx_q <= idx_q + 1'b1;
        end
        ST_SCAN_S: begin
          if (s_end || s_hit) idx_q <= '0;
          else idx_q <= idx_q + 1'b1;
          if (s_ctrl.shift_en) scnt_q <= scnt_q - 1'b1;
        end
        ST_SCAN_C: begin
          if (!c_end && !c_hit) idx_q <= idx_q + 1'b1;
          if (div_start) found_q <= 1'b1;
        end
        ST_UPD: begin
          if (act_e'(act_q) == ACT_DEL_CYCLIC) begin
            if (found_q) ccnt_q <= ccnt_q - 1'b1;
          end else if (!found_q && !c_full) begin
            ccnt_q <= ccnt_q + 1'b1;
          end
        end
        default: begin
          found_q <= found_q;
        end
      endcase
    end
  end

  // request and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q           <= action_i;
      ready_q         <= tx_ready_i;
      now_q           <= time_ms_i;
      new_s_q.id      <= frame_id_i;
      new_s_q.len     <= frame_len_i;
      new_s_q.data    <= frame_data_i;
      new_s_q.tm      <= time_ms_i;
      new_s_q.per     <= '0;
      new_c_q.id      <= frame_id_i;
      new_c_q.len     <= frame_len_i;
      new_c_q.data    <= frame_data_i;
      new_c_q.tm      <= time_ms_i;
      new_c_q.per     <= (interval_ms_i == '0) ? TIME_W'(1) : interval_ms_i;
      sent_q          <= 1'b0;
      kind_q          <= 1'b0;
      id_q            <= '0;
      len_q           <= '0;
      data_q          <= '0;
      due_q           <= 1'b0;
      full_q          <= 1'b0;
    end
    case (state_q)
      ST_ADD: full_q <= !s_ctrl.load_en;
      ST_SCAN_S: begin
        if (s_ctrl.shift_en) begin
          sent_q <= 1'b1;
          id_q   <= s_rd.id;
          len_q  <= s_rd.len;
          data_q <= s_rd.data;
        end
      end
      ST_SCAN_C: begin
        if (!c_end && c_hit) due_q <= 1'b1;
        if (div_start) begin
          sent_q  <= 1'b1;
          kind_q  <= 1'b1;
          id_q    <= c_rd.id;
          len_q   <= c_rd.len;
          data_q  <= c_rd.data;
          new_c_q <= c_rd;
        end
      end
      ST_DIV: begin
        // next due time is now minus remainder plus one interval
        if (div_done) new_c_q.tm <= now_q - div_rem + new_c_q.per;
      end
      ST_UPD: begin
        if (act_e'(act_q) == ACT_ADD_CYCLIC) full_q <= !found_q && c_full;
      end
      default: ;
    endcase
  end

  assign busy        = state_q != ST_IDLE;
  assign done_o      = state_q == ST_RESP;
  assign sent_o      = sent_q;
  assign sent_kind_o = kind_q;
  assign tx_id_o     = id_q;
  assign tx_len_o    = len_q;
  assign tx_data_o   = data_q;
  assign any_due_o   = due_q;
  assign list_full_o = full_q;

endmodule
